FILE: hdl/fibonacci_mod_prime_defines.svh
// assertion macros for the fibonacci block
`ifndef FIBONACCI_MOD_PRIME_DEFINES_SVH
`define FIBONACCI_MOD_PRIME_DEFINES_SVH

// checked property, off while reset is high
`define FMP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked property, also during reset
`define FMP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/fmp_pkg.sv
package fmp_pkg;

  localparam int VALUE_W   = 30;
  localparam int INDEX_W   = 63;
  localparam int MUL_STEPS = VALUE_W;
  localparam int SUM_W     = VALUE_W + 2;

  localparam logic [VALUE_W-1:0] FIB_PRIME = 30'd1000000007;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PREP   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_ADD    = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    MUL_EVEN   = 2'd0,
    MUL_FK_SQ  = 2'd1,
    MUL_FK1_SQ = 2'd2
  } mul_sel_t;

  // reduces a value below three times the prime
  function automatic logic [VALUE_W-1:0] mod_red3(input logic [SUM_W-1:0] t);
    logic [SUM_W-1:0] p1;
    logic [SUM_W-1:0] p2;
    p1 = {2'b00, FIB_PRIME};
    p2 = {1'b0, FIB_PRIME, 1'b0};
    if (t >= p2) begin
      mod_red3 = VALUE_W'(t - p2);
    end else if (t >= p1) begin
      mod_red3 = VALUE_W'(t - p1);
    end else begin
      mod_red3 = VALUE_W'(t);
    end
  endfunction

  function automatic logic [VALUE_W-1:0] mod_add(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
    mod_add = mod_red3({2'b00, a} + {2'b00, b});
  endfunction

endpackage

FILE: hdl/fibonacci_mod_prime.sv
// Fibonacci number of an index, modulo 1000000007.
// Input channel: in_valid / in_ready carry one word, index_n; only its low
// INDEX_BITS bits form the index. Output channel: out_valid / out_ready carry
// one word, fib_value, in 0..1000000006. Every input word gives one output word.
// The index is walked from its top bit down by fast doubling. Per index bit the
// block forms 2F(k+1)-F(k) in the PREP state, computes three modular products
// one after another on one bit-serial multiplier, and does modular adds in the
// ADD and UPDATE states. A new word is taken only after the previous result has
// been written to the output register.
// The result sits in an output register: a new index is taken and worked on
// while an earlier result still waits for out_ready. If a finished result meets
// a full output register the block holds it until the receiver takes the
// older word. Synchronous reset (rst high) returns the block to idle with
// out_valid low; no partial work survives.
`include "fibonacci_mod_prime_defines.svh"

module fibonacci_mod_prime #(
  parameter int INDEX_BITS = 63
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fmp_pkg::INDEX_W-1:0]    index_n,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fmp_pkg::VALUE_W-1:0]    fib_value
);

  localparam int VW    = fmp_pkg::VALUE_W;
  localparam int SW    = fmp_pkg::SUM_W;
  localparam int CNT_W = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
  localparam int MC_W  = $clog2(fmp_pkg::MUL_STEPS);

  fmp_pkg::state_t   state;
  fmp_pkg::mul_sel_t mul_sel;

  logic [INDEX_BITS-1:0] idx;
  logic [CNT_W-1:0]      bit_cnt;
  logic [MC_W-1:0]       mul_cnt;
  logic [VW-1:0]         fk;
  logic [VW-1:0]         fk1;
  logic [VW-1:0]         mul_a;
  logic [VW-1:0]         mul_b;
  logic [VW-1:0]         acc;
  logic [VW-1:0]         prod_even;
  logic [VW-1:0]         prod_sq;
  logic [VW-1:0]         prod_sq1;
  logic [VW-1:0]         odd;

  logic [SW-1:0] mul_sum;
  logic [VW-1:0] acc_next;
  logic [VW-1:0] twice_next;
  logic          out_free;

  // one multiplier bit per cycle, top bit first
  assign mul_sum    = {1'b0, acc, 1'b0} + (mul_b[VW-1] ? {2'b00, mul_a} : '0);
  assign acc_next   = fmp_pkg::mod_red3(mul_sum);
  assign twice_next = fmp_pkg::mod_red3({1'b0, fk1, 1'b0}
                                        + {2'b00, fmp_pkg::FIB_PRIME}
                                        - {2'b00, fk});

  assign in_ready = !rst && (state == fmp_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fmp_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        fmp_pkg::ST_IDLE: begin
          if (in_valid) begin
            idx     <= index_n[INDEX_BITS-1:0];
            bit_cnt <= CNT_W'(INDEX_BITS - 1);
            fk      <= '0;
            fk1     <= VW'(1);
            state   <= fmp_pkg::ST_PREP;
          end
        end
        fmp_pkg::ST_PREP: begin
          mul_a   <= fk;
          mul_b   <= twice_next;
          acc     <= '0;
          mul_cnt <= MC_W'(fmp_pkg::MUL_STEPS - 1);
          mul_sel <= fmp_pkg::MUL_EVEN;
          state   <= fmp_pkg::ST_MUL;
        end
        fmp_pkg::ST_MUL: begin
          mul_b <= {mul_b[VW-2:0], 1'b0};
          if (mul_cnt != '0) begin
            acc     <= acc_next;
            mul_cnt <= mul_cnt - MC_W'(1);
          end else begin
            acc     <= '0;
            mul_cnt <= MC_W'(fmp_pkg::MUL_STEPS - 1);
            case (mul_sel)
              fmp_pkg::MUL_EVEN: begin
                prod_even <= acc_next;
                mul_a     <= fk;
                mul_b     <= fk;
                mul_sel   <= fmp_pkg::MUL_FK_SQ;
              end
              fmp_pkg::MUL_FK_SQ: begin
                prod_sq <= acc_next;
                mul_a   <= fk1;
                mul_b   <= fk1;
                mul_sel <= fmp_pkg::MUL_FK1_SQ;
              end
              default: begin
                prod_sq1 <= acc_next;
                state    <= fmp_pkg::ST_ADD;
              end
            endcase
          end
        end
        fmp_pkg::ST_ADD: begin
          odd   <= fmp_pkg::mod_add(prod_sq, prod_sq1);
          state <= fmp_pkg::ST_UPDATE;
        end
        fmp_pkg::ST_UPDATE: begin
          if (idx[INDEX_BITS-1]) begin
            fk  <= odd;
            fk1 <= fmp_pkg::mod_add(prod_even, odd);
          end else begin
            fk  <= prod_even;
            fk1 <= odd;
          end
          idx <= idx << 1;
          if (bit_cnt == '0) begin
            state <= fmp_pkg::ST_FINISH;
          end else begin
            bit_cnt <= bit_cnt - CNT_W'(1);
            state   <= fmp_pkg::ST_PREP;
          end
        end
        fmp_pkg::ST_FINISH: begin
          if (out_free) begin
            fib_value <= fk;
            out_valid <= 1'b1;
            state     <= fmp_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= fmp_pkg::ST_IDLE;
        end
      endcase
    end
  end

  `FMP_ASSERT(a_acc_reduced, (state == fmp_pkg::ST_MUL) |-> (acc < fmp_pkg::FIB_PRIME), "partial product not reduced")
  `FMP_ASSERT(a_pair_reduced, (state == fmp_pkg::ST_PREP) |-> ((fk < fmp_pkg::FIB_PRIME) && (fk1 < fmp_pkg::FIB_PRIME)), "fibonacci pair not reduced")
  `FMP_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state == fmp_pkg::ST_PREP), "accepted word did not start the walk")
  `FMP_ASSERT(a_last_product, ((state == fmp_pkg::ST_MUL) && (mul_cnt == '0) && (mul_sel == fmp_pkg::MUL_FK1_SQ)) |=> (state == fmp_pkg::ST_ADD), "third product did not lead to the add step")
  `FMP_ASSERT(a_result_source, $rose(out_valid) |-> ($past(state) == fmp_pkg::ST_FINISH), "result word shown outside finish")

endmodule
